FILE: hdl/mpd_pkg.sv
// shared types and constants of the mouse packet event decoder
`timescale 1ns / 1ps
package mpd_pkg;

  localparam logic [2:0] PKT_LAST      = 3'd7;
  localparam int         SYNC_IDX      = 7;
  localparam logic [2:0] MASK_RELEASED = 3'b111;

  localparam logic [1:0] KIND_SCROLL = 2'd0;
  localparam logic [1:0] KIND_MOTION = 2'd1;
  localparam logic [1:0] KIND_BUTTON = 2'd2;

  localparam logic [1:0] ID_LEFT   = 2'd0;
  localparam logic [1:0] ID_MIDDLE = 2'd1;
  localparam logic [1:0] ID_RIGHT  = 2'd2;

  // mask bit of each button, active low
  localparam int MASK_LEFT   = 2;
  localparam int MASK_MIDDLE = 1;
  localparam int MASK_RIGHT  = 0;

  localparam int NUM_EVT = 5;

  // one-hot event codes, in emission order
  localparam logic [NUM_EVT-1:0] EVT_SCROLL = 5'b00001;
  localparam logic [NUM_EVT-1:0] EVT_MOTION = 5'b00010;
  localparam logic [NUM_EVT-1:0] EVT_LEFT   = 5'b00100;
  localparam logic [NUM_EVT-1:0] EVT_MIDDLE = 5'b01000;
  localparam logic [NUM_EVT-1:0] EVT_RIGHT  = 5'b10000;

  typedef struct packed {
    logic [NUM_EVT-1:0] pending;
    logic signed [8:0]  dx;
    logic signed [9:0]  dy;
    logic signed [7:0]  wd;
    logic [2:0]         mask;
  } desc_t;

endpackage

FILE: hdl/mpd_front.sv
// byte collector and packet classifier of the mouse packet event decoder
`timescale 1ns / 1ps
module mpd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_packet_byte,
  output logic          q_push,
  input  logic          q_ready,
  output mpd_pkg::desc_t q_desc
);

  logic [2:0] pos_r;
  logic [2:0] pos_nxt;
  logic [7:0] held_r [0:6];
  logic [2:0] mask_r;
  logic [2:0] mask_nxt;
  logic       acc;
  logic       at_last;
  logic       good;
  logic [2:0] changed;
  logic signed [8:0] sum_x;
  logic signed [8:0] sum_y;
  logic signed [7:0] sum_w;
  logic [mpd_pkg::NUM_EVT-1:0] pend;

  assign at_last  = (pos_r == mpd_pkg::PKT_LAST);
  assign in_ready = !at_last || q_ready;
  assign acc      = in_valid && in_ready;
  assign good     = held_r[0][mpd_pkg::SYNC_IDX] && !in_packet_byte[mpd_pkg::SYNC_IDX];

  assign sum_x = $signed({held_r[1][7], held_r[1]}) + $signed({held_r[3][7], held_r[3]});
  assign sum_y = $signed({held_r[2][7], held_r[2]}) + $signed({held_r[4][7], held_r[4]});
  assign sum_w = $signed({held_r[5][6], held_r[5][6:0]})
               + $signed({held_r[6][6], held_r[6][6:0]});
  assign changed = held_r[0][2:0] ^ mask_r;

  always_comb begin
    pend = '0;
    if (sum_w != 8'sd0) pend = pend | mpd_pkg::EVT_SCROLL;
    if (sum_x != 9'sd0 || sum_y != 9'sd0) pend = pend | mpd_pkg::EVT_MOTION;
    if (changed[mpd_pkg::MASK_LEFT]) pend = pend | mpd_pkg::EVT_LEFT;
    if (changed[mpd_pkg::MASK_MIDDLE]) pend = pend | mpd_pkg::EVT_MIDDLE;
    if (changed[mpd_pkg::MASK_RIGHT]) pend = pend | mpd_pkg::EVT_RIGHT;
  end

  always_comb begin
    q_desc.pending = pend;
    q_desc.dx      = sum_x;
    q_desc.dy      = -$signed({sum_y[8], sum_y});
    q_desc.wd      = sum_w;
    q_desc.mask    = held_r[0][2:0];
  end

  assign q_push = acc && at_last && good && (pend != '0);

  always_comb begin
    pos_nxt  = pos_r;
    mask_nxt = mask_r;
    if (acc) begin
      pos_nxt = pos_r + 3'd1;
      if (at_last && good) begin
        mask_nxt = held_r[0][2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      mask_r <= mpd_pkg::MASK_RELEASED;
    end else begin
      pos_r  <= pos_nxt;
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !at_last) begin
      held_r[pos_r] <= in_packet_byte;
    end
  end

  a_push_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> at_last && q_ready)
    else $error("packet request pushed away from the last byte");

endmodule

FILE: hdl/mpd_fifo.sv
// short packet queue between the classifier and the event sequencer
`timescale 1ns / 1ps
module mpd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           push_ready,
  input  mpd_pkg::desc_t push_desc,
  output logic           pop_valid,
  input  logic           pop,
  output mpd_pkg::desc_t pop_desc
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  mpd_pkg::desc_t mem_r [0:DEPTH-1];
  logic [PW-1:0] wr_r;
  logic [PW-1:0] rd_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (cnt_r != CNT_MAX);
  assign pop_valid  = (cnt_r != '0);
  assign pop_desc   = mem_r[rd_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_r <= (wr_r == PTR_MAX) ? '0 : wr_r + PW'(1);
      if (do_pop) rd_r <= (rd_r == PTR_MAX) ? '0 : rd_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_desc;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("queue count beyond depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("queue count missed a push");

endmodule

FILE: hdl/mpd_back.sv
// event sequencer and output register of the mouse packet event decoder
`timescale 1ns / 1ps
module mpd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  mpd_pkg::desc_t q_desc,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_event_kind,
  output logic signed [8:0] out_delta_x,
  output logic signed [9:0] out_delta_y,
  output logic signed [7:0] out_wheel_delta,
  output logic [1:0]     out_button_id,
  output logic           out_pressed,
  output logic           out_last_event
);

  mpd_pkg::desc_t desc_r;
  logic [mpd_pkg::NUM_EVT-1:0] pend_r;
  logic [mpd_pkg::NUM_EVT-1:0] pend_nxt;
  logic [mpd_pkg::NUM_EVT-1:0] sel;
  logic [mpd_pkg::NUM_EVT-1:0] rest;
  logic busy;
  logic load_out;
  logic out_valid_r;
  logic out_valid_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic signed [8:0] dx_r, dx_nxt;
  logic signed [9:0] dy_r, dy_nxt;
  logic signed [7:0] wd_r, wd_nxt;
  logic [1:0] id_r, id_nxt;
  logic pr_r, pr_nxt;
  logic last_r;

  assign busy     = (pend_r != '0);
  assign load_out = busy && (!out_valid_r || out_ready);
  assign sel      = pend_r & (~pend_r + 5'd1);
  assign rest     = pend_r & ~sel;
  assign q_pop    = q_valid && (!busy || (load_out && rest == '0));

  always_comb begin
    pend_nxt = pend_r;
    if (q_pop) pend_nxt = q_desc.pending;
    else if (load_out) pend_nxt = rest;
  end

  always_comb begin
    kind_nxt = mpd_pkg::KIND_SCROLL;
    dx_nxt   = '0;
    dy_nxt   = '0;
    wd_nxt   = '0;
    id_nxt   = mpd_pkg::ID_LEFT;
    pr_nxt   = 1'b0;
    case (sel)
      mpd_pkg::EVT_SCROLL: begin
        wd_nxt = desc_r.wd;
      end
      mpd_pkg::EVT_MOTION: begin
        kind_nxt = mpd_pkg::KIND_MOTION;
        dx_nxt   = desc_r.dx;
        dy_nxt   = desc_r.dy;
      end
      mpd_pkg::EVT_LEFT: begin
        kind_nxt = mpd_pkg::KIND_BUTTON;
        id_nxt   = mpd_pkg::ID_LEFT;
        pr_nxt   = !desc_r.mask[mpd_pkg::MASK_LEFT];
      end
      mpd_pkg::EVT_MIDDLE: begin
        kind_nxt = mpd_pkg::KIND_BUTTON;
        id_nxt   = mpd_pkg::ID_MIDDLE;
        pr_nxt   = !desc_r.mask[mpd_pkg::MASK_MIDDLE];
      end
      mpd_pkg::EVT_RIGHT: begin
        kind_nxt = mpd_pkg::KIND_BUTTON;
        id_nxt   = mpd_pkg::ID_RIGHT;
        pr_nxt   = !desc_r.mask[mpd_pkg::MASK_RIGHT];
      end
      default: begin
        kind_nxt = mpd_pkg::KIND_SCROLL;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) desc_r <= q_desc;
    if (load_out) begin
      kind_r <= kind_nxt;
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      wd_r   <= wd_nxt;
      id_r   <= id_nxt;
      pr_r   <= pr_nxt;
      last_r <= (rest == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = kind_r;
  assign out_delta_x     = dx_r;
  assign out_delta_y     = dy_r;
  assign out_wheel_delta = wd_r;
  assign out_button_id   = id_r;
  assign out_pressed     = pr_r;
  assign out_last_event  = last_r;

  a_last_tracks_rest: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_last_event == ($past(rest) == '0))
    else $error("last event flag out of step with pending events");

  a_no_early_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && busy |-> load_out && rest == '0)
    else $error("packet request popped while events remain");

endmodule

FILE: hdl/mouse_packet_event_decoder.sv
// top level of the mouse packet event decoder
// first event of a packet: via queue, pending register and output register
// throughput: one byte per cycle in, one event per cycle out while out_ready is high
// the last byte of a packet stalls only while the packet queue is full
// reset: byte position to zero, button mask to all released, queue and output empty
`timescale 1ns / 1ps
module mouse_packet_event_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_packet_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_event_kind,
  output logic signed [8:0] out_delta_x,
  output logic signed [9:0] out_delta_y,
  output logic signed [7:0] out_wheel_delta,
  output logic [1:0]        out_button_id,
  output logic              out_pressed,
  output logic              out_last_event
);

  logic           push;
  logic           push_ready;
  mpd_pkg::desc_t push_desc;
  logic           pop_valid;
  logic           pop;
  mpd_pkg::desc_t pop_desc;

  mpd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_packet_byte (in_packet_byte),
    .q_push         (push),
    .q_ready        (push_ready),
    .q_desc         (push_desc)
  );

  mpd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_desc   (pop_desc)
  );

  mpd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (pop_valid),
    .q_pop           (pop),
    .q_desc          (pop_desc),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_delta_x     (out_delta_x),
    .out_delta_y     (out_delta_y),
    .out_wheel_delta (out_wheel_delta),
    .out_button_id   (out_button_id),
    .out_pressed     (out_pressed),
    .out_last_event  (out_last_event)
  );

endmodule

FILE: sim/tb.sv
// testbench for the mouse packet event decoder: random byte streams checked against predicted events
`timescale 1ns / 1ps

typedef struct packed {
  logic [1:0]        kind;
  logic signed [8:0] dx;
  logic signed [9:0] dy;
  logic signed [7:0] wd;
  logic [1:0]        button;
  logic              pressed;
  logic              last;
} mouse_event_t;

class mouse_event_tracker;
  logic [2:0]   byte_pos;
  logic [7:0]   held [7];
  logic [2:0]   button_mask;
  mouse_event_t pending_events [$];
  int           mismatches;

  function new();
    byte_pos = '0;
    foreach (held[i]) held[i] = '0;
    button_mask = mpd_pkg::MASK_RELEASED;
    mismatches = 0;
  endfunction

  function int waiting();
    return pending_events.size();
  endfunction

  task flag_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // one accepted request: hold it, or decode the packet on its last byte
  function void take_byte(logic [7:0] b);
    int           dx;
    int           dy;
    int           wd;
    logic [2:0]   new_mask;
    logic [1:0]   btn_ids [3];
    int           mask_bits [3];
    mouse_event_t ev;
    mouse_event_t burst [$];
    btn_ids = '{mpd_pkg::ID_LEFT, mpd_pkg::ID_MIDDLE, mpd_pkg::ID_RIGHT};
    mask_bits = '{mpd_pkg::MASK_LEFT, mpd_pkg::MASK_MIDDLE, mpd_pkg::MASK_RIGHT};
    if (byte_pos != mpd_pkg::PKT_LAST) begin
      held[byte_pos] = b;
      byte_pos = byte_pos + 3'd1;
      return;
    end
    byte_pos = '0;
    if (!held[0][mpd_pkg::SYNC_IDX] || b[mpd_pkg::SYNC_IDX]) return;
    dx = $signed(held[1]) + $signed(held[3]);
    dy = -($signed(held[2]) + $signed(held[4]));
    wd = $signed(held[5][6:0]) + $signed(held[6][6:0]);
    new_mask = held[0][2:0];
    if (wd != 0) begin
      ev = '0;
      ev.kind = mpd_pkg::KIND_SCROLL;
      ev.wd = 8'(wd);
      burst.push_back(ev);
    end
    if (dx != 0 || dy != 0) begin
      ev = '0;
      ev.kind = mpd_pkg::KIND_MOTION;
      ev.dx = 9'(dx);
      ev.dy = 10'(dy);
      burst.push_back(ev);
    end
    for (int i = 0; i < 3; i++) begin
      if (new_mask[mask_bits[i]] != button_mask[mask_bits[i]]) begin
        ev = '0;
        ev.kind = mpd_pkg::KIND_BUTTON;
        ev.button = btn_ids[i];
        ev.pressed = !new_mask[mask_bits[i]];
        burst.push_back(ev);
      end
    end
    button_mask = new_mask;
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) pending_events.push_back(burst[i]);
  endfunction

  task match_event(mouse_event_t got);
    mouse_event_t want;
    if (pending_events.size() == 0) begin
      flag_mismatch($sformatf("event of kind %0d with none expected", got.kind));
      return;
    end
    want = pending_events.pop_front();
    if (got.kind !== want.kind)
      flag_mismatch($sformatf("event_kind got %0d want %0d", got.kind, want.kind));
    if (got.dx !== want.dx)
      flag_mismatch($sformatf("delta_x got %0d want %0d", got.dx, want.dx));
    if (got.dy !== want.dy)
      flag_mismatch($sformatf("delta_y got %0d want %0d", got.dy, want.dy));
    if (got.wd !== want.wd)
      flag_mismatch($sformatf("wheel_delta got %0d want %0d", got.wd, want.wd));
    if (got.button !== want.button)
      flag_mismatch($sformatf("button_id got %0d want %0d", got.button, want.button));
    if (got.pressed !== want.pressed)
      flag_mismatch($sformatf("pressed got %0b want %0b", got.pressed, want.pressed));
    if (got.last !== want.last)
      flag_mismatch($sformatf("last_event got %0b want %0b", got.last, want.last));
  endtask
endclass

module tb;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_BYTES = 56;
  localparam int IDLE_PLAN [4] = '{0, 72, 0, 6};
  localparam int STALL_PLAN [4] = '{0, 0, 72, 6};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_packet_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_event_kind;
  logic signed [8:0] out_delta_x;
  logic signed [9:0] out_delta_y;
  logic signed [7:0] out_wheel_delta;
  logic [1:0]        out_button_id;
  logic              out_pressed;
  logic              out_last_event;

  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         bytes_sent = 0;
  logic [2:0] stream_pos = '0;
  logic [2:0] last_mask = mpd_pkg::MASK_RELEASED;

  mouse_event_tracker tracker = new();

  mouse_packet_event_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_packet_byte  (in_packet_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_delta_x     (out_delta_x),
    .out_delta_y     (out_delta_y),
    .out_wheel_delta (out_wheel_delta),
    .out_button_id   (out_button_id),
    .out_pressed     (out_pressed),
    .out_last_event  (out_last_event)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.take_byte(in_packet_byte);
      if (out_valid && out_ready) begin
        tracker.match_event({out_event_kind, out_delta_x, out_delta_y, out_wheel_delta,
                             out_button_id, out_pressed, out_last_event});
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("mouse_packet_event_decoder verification failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_packet_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    stream_pos = stream_pos + 3'd1;
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] frame [8]);
    // fill out any broken packet so the frame lands on a packet boundary
    while (stream_pos != '0) send_byte(8'($urandom));
    foreach (frame[i]) send_byte(frame[i]);
  endtask

  task automatic send_random_unit();
    logic [7:0] frame [8];
    int         pick;
    foreach (frame[i]) frame[i] = 8'($urandom);
    if ($urandom_range(0, 99) < 40) frame[0][2:0] = last_mask;
    if ($urandom_range(0, 99) < 25) begin
      frame[1] = '0;
      frame[3] = '0;
    end
    if ($urandom_range(0, 99) < 25) begin
      frame[2] = '0;
      frame[4] = '0;
    end
    if ($urandom_range(0, 99) < 10) frame[3] = -frame[1];
    if ($urandom_range(0, 99) < 30) begin
      frame[5][6:0] = '0;
      frame[6][6:0] = '0;
    end
    frame[0][mpd_pkg::SYNC_IDX] = 1'b1;
    frame[mpd_pkg::PKT_LAST][mpd_pkg::SYNC_IDX] = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick >= 95) begin
      repeat ($urandom_range(1, 7)) send_byte(8'($urandom));
      return;
    end
    if (pick >= 88) frame[mpd_pkg::PKT_LAST][mpd_pkg::SYNC_IDX] = 1'b1;
    else if (pick >= 80) frame[0][mpd_pkg::SYNC_IDX] = 1'b0;
    else last_mask = frame[0][2:0];
    send_frame(frame);
  endtask

  // hold off the sender until every predicted event is out
  task automatic drain_events();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.waiting() != 0) @(posedge clk);
  endtask

  initial begin
    int target;
    target = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // all pressed, most negative x motion and wheel, most positive y
    send_frame('{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h40, 8'h40, 8'h00});
    // all released, most positive x motion and wheel, most negative y, wheel byte top bit set
    send_frame('{8'h87, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'hbf, 8'hbf, 8'h7f});
    // bad tail byte
    send_frame('{8'hfa, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'hff});
    // valid packet with nothing changed
    send_frame('{8'h87, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h80, 8'h00});
    drain_events();
    target = bytes_sent;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = IDLE_PLAN[p];
      recv_stall_pct = STALL_PLAN[p];
      target += PHASE_BYTES;
      while (bytes_sent < target) send_random_unit();
      drain_events();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.waiting() == 0)
      $display("mouse_packet_event_decoder verification clean");
    else
      $display("mouse_packet_event_decoder verification failed");
    $finish;
  end
endmodule
